FILE: rtl/core/rtch_pkg.sv
// shared types, widths and codes for the ray/triangle closest-hit block
`default_nettype none
package rtch_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int CELL_INDEX_WIDTH = 16;
    localparam int DIR_WIDTH        = 16;
    localparam int EPS_WIDTH        = 16;
    localparam int DIST_WIDTH       = 25;
    localparam int FRAC_SHIFT       = 14;
    localparam int SAT_SHIFT        = DIST_WIDTH - FRAC_SHIFT;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int BW  = DW;
    localparam int PW  = COORD_WIDTH + DIR_WIDTH + 2;
    localparam int QW  = 2 * DW + 1;
    localparam int AW  = 3 * COORD_WIDTH + 34;

    localparam int DIV_STEPS = DIST_WIDTH;
    localparam int CNT_MAX   = (BW > DIV_STEPS) ? BW : DIV_STEPS;
    localparam int CNT_W     = $clog2(CNT_MAX);
    localparam int STEP_W    = 5;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = COORD_WIDTH;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;
    localparam logic signed [DIR_WIDTH-1:0] DIR_ONE = DIR_WIDTH'(16384);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_X       = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Y       = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIR_Z       = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DET_EPSILON = 3'd6;

    // multiply-accumulate steps
    localparam logic [STEP_W-1:0] S_P0A = 5'd0;
    localparam logic [STEP_W-1:0] S_P0B = 5'd1;
    localparam logic [STEP_W-1:0] S_P1A = 5'd2;
    localparam logic [STEP_W-1:0] S_P1B = 5'd3;
    localparam logic [STEP_W-1:0] S_P2A = 5'd4;
    localparam logic [STEP_W-1:0] S_P2B = 5'd5;
    localparam logic [STEP_W-1:0] S_DET0 = 5'd6;
    localparam logic [STEP_W-1:0] S_DET1 = 5'd7;
    localparam logic [STEP_W-1:0] S_DET2 = 5'd8;
    localparam logic [STEP_W-1:0] S_UN0 = 5'd9;
    localparam logic [STEP_W-1:0] S_UN1 = 5'd10;
    localparam logic [STEP_W-1:0] S_UN2 = 5'd11;
    localparam logic [STEP_W-1:0] S_Q0A = 5'd12;
    localparam logic [STEP_W-1:0] S_Q0B = 5'd13;
    localparam logic [STEP_W-1:0] S_Q1A = 5'd14;
    localparam logic [STEP_W-1:0] S_Q1B = 5'd15;
    localparam logic [STEP_W-1:0] S_Q2A = 5'd16;
    localparam logic [STEP_W-1:0] S_Q2B = 5'd17;
    localparam logic [STEP_W-1:0] S_VN0 = 5'd18;
    localparam logic [STEP_W-1:0] S_VN1 = 5'd19;
    localparam logic [STEP_W-1:0] S_VN2 = 5'd20;
    localparam logic [STEP_W-1:0] S_TN0 = 5'd21;
    localparam logic [STEP_W-1:0] S_TN1 = 5'd22;
    localparam logic [STEP_W-1:0] S_TN2 = 5'd23;
    localparam logic [STEP_W-1:0] S_HX = 5'd24;
    localparam logic [STEP_W-1:0] S_HY = 5'd25;
    localparam logic [STEP_W-1:0] S_HZ = 5'd26;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LATCH  = 4'd1;
    localparam logic [3:0] OP_LOAD   = 4'd2;
    localparam logic [3:0] OP_ITER   = 4'd3;
    localparam logic [3:0] OP_STORE  = 4'd4;
    localparam logic [3:0] OP_NORM   = 4'd5;
    localparam logic [3:0] OP_CHECK  = 4'd6;
    localparam logic [3:0] OP_DIVI   = 4'd7;
    localparam logic [3:0] OP_DIV    = 4'd8;
    localparam logic [3:0] OP_UPDATE = 4'd9;
    localparam logic [3:0] OP_EMIT   = 4'd10;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
        logic [CELL_INDEX_WIDTH-1:0]   cell_index;
        logic                          last_of_query;
    } tri_word_t;

    typedef struct packed {
        logic                          hit;
        logic [CELL_INDEX_WIDTH-1:0]   best_cell;
        logic [DIST_WIDTH-1:0]         distance;
        logic signed [COORD_WIDTH-1:0] hit_x;
        logic signed [COORD_WIDTH-1:0] hit_y;
        logic signed [COORD_WIDTH-1:0] hit_z;
    } hit_word_t;

    typedef struct packed {
        logic [3:0]        op;
        logic [STEP_W-1:0] step;
        logic              last_bit;
    } rtch_cmd_t;

    typedef struct packed {
        logic tri_hit;
        logic sat;
        logic last;
        logic any_hit;
        logic out_busy;
    } rtch_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/rtch_datapath.sv
// datapath: ray registers, shift-add multiply-accumulate, divider, best hit, output word
`default_nettype none
module rtch_datapath import rtch_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tri_word_t                  s_data,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire rtch_cmd_t                  cmd,
    output rtch_status_t                    status,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output hit_word_t                       m_data
);

    localparam logic signed [AW-1:0] HIT_HI =
        {{(AW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] HIT_LO = ~HIT_HI;

    localparam logic [1:0] M_CLEAR  = 2'd0;
    localparam logic [1:0] M_ACC    = 2'd1;
    localparam logic [1:0] M_PRESET = 2'd2;

    logic signed [COORD_WIDTH-1:0] origin_reg [3];
    logic signed [DIR_WIDTH-1:0]   dir_reg [3];
    logic [EPS_WIDTH-1:0]          eps_reg;

    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [DW-1:0] tv_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [QW-1:0] q_reg [3];
    logic signed [AW-1:0] det_reg, un_reg, vn_reg, tn_reg;
    logic signed [AW-1:0] acc_reg, a_reg;
    logic signed [BW-1:0] b_reg;
    logic [AW-1:0]        rem_reg;
    logic [DIST_WIDTH-1:0] num_reg, dist_reg;
    logic [CELL_INDEX_WIDTH-1:0] cell_reg;
    logic                 last_reg, tri_hit_reg;

    logic [DIST_WIDTH-1:0]       near_dist_reg;
    logic [CELL_INDEX_WIDTH-1:0] near_cell_reg;
    logic                        any_hit_reg;
    logic signed [COORD_WIDTH-1:0] hc_reg [3];

    logic      m_valid_reg;
    hit_word_t m_data_reg;

    logic signed [AW-1:0] op_a, a_load, hs, sum_uv;
    logic signed [BW-1:0] op_b;
    logic                 op_neg, miss, sat;
    logic [1:0]           op_mode;
    logic [1:0]           op_axis;
    logic signed [COORD_WIDTH-1:0] hs_sat;
    logic [AW-1:0]        rem_shift;

    always_comb begin
        op_a = AW'(e2_reg[2]);
        op_b = BW'(dir_reg[1]);
        op_neg = 1'b0;
        op_mode = M_CLEAR;
        op_axis = 2'd0;
        case (cmd.step)
            S_P0A: begin op_a = AW'(e2_reg[2]); op_b = BW'(dir_reg[1]); end
            S_P0B: begin
                op_a = AW'(e2_reg[1]); op_b = BW'(dir_reg[2]); op_neg = 1'b1; op_mode = M_ACC;
            end
            S_P1A: begin op_a = AW'(e2_reg[0]); op_b = BW'(dir_reg[2]); end
            S_P1B: begin
                op_a = AW'(e2_reg[2]); op_b = BW'(dir_reg[0]); op_neg = 1'b1; op_mode = M_ACC;
            end
            S_P2A: begin op_a = AW'(e2_reg[1]); op_b = BW'(dir_reg[0]); end
            S_P2B: begin
                op_a = AW'(e2_reg[0]); op_b = BW'(dir_reg[1]); op_neg = 1'b1; op_mode = M_ACC;
            end
            S_DET0: begin op_a = AW'(p_reg[0]); op_b = e1_reg[0]; end
            S_DET1: begin op_a = AW'(p_reg[1]); op_b = e1_reg[1]; op_mode = M_ACC; end
            S_DET2: begin op_a = AW'(p_reg[2]); op_b = e1_reg[2]; op_mode = M_ACC; end
            S_UN0: begin op_a = AW'(p_reg[0]); op_b = tv_reg[0]; end
            S_UN1: begin op_a = AW'(p_reg[1]); op_b = tv_reg[1]; op_mode = M_ACC; end
            S_UN2: begin op_a = AW'(p_reg[2]); op_b = tv_reg[2]; op_mode = M_ACC; end
            S_Q0A: begin op_a = AW'(e1_reg[2]); op_b = tv_reg[1]; end
            S_Q0B: begin
                op_a = AW'(e1_reg[1]); op_b = tv_reg[2]; op_neg = 1'b1; op_mode = M_ACC;
            end
            S_Q1A: begin op_a = AW'(e1_reg[0]); op_b = tv_reg[2]; end
            S_Q1B: begin
                op_a = AW'(e1_reg[2]); op_b = tv_reg[0]; op_neg = 1'b1; op_mode = M_ACC;
            end
            S_Q2A: begin op_a = AW'(e1_reg[1]); op_b = tv_reg[0]; end
            S_Q2B: begin
                op_a = AW'(e1_reg[0]); op_b = tv_reg[1]; op_neg = 1'b1; op_mode = M_ACC;
            end
            S_VN0: begin op_a = AW'(q_reg[0]); op_b = BW'(dir_reg[0]); end
            S_VN1: begin op_a = AW'(q_reg[1]); op_b = BW'(dir_reg[1]); op_mode = M_ACC; end
            S_VN2: begin op_a = AW'(q_reg[2]); op_b = BW'(dir_reg[2]); op_mode = M_ACC; end
            S_TN0: begin op_a = AW'(q_reg[0]); op_b = e2_reg[0]; end
            S_TN1: begin op_a = AW'(q_reg[1]); op_b = e2_reg[1]; op_mode = M_ACC; end
            S_TN2: begin op_a = AW'(q_reg[2]); op_b = e2_reg[2]; op_mode = M_ACC; end
            S_HX: begin
                op_a = AW'({1'b0, near_dist_reg}); op_b = BW'(dir_reg[0]);
                op_mode = M_PRESET; op_axis = 2'd0;
            end
            S_HY: begin
                op_a = AW'({1'b0, near_dist_reg}); op_b = BW'(dir_reg[1]);
                op_mode = M_PRESET; op_axis = 2'd1;
            end
            S_HZ: begin
                op_a = AW'({1'b0, near_dist_reg}); op_b = BW'(dir_reg[2]);
                op_mode = M_PRESET; op_axis = 2'd2;
            end
            default: begin end
        endcase
        a_load = op_neg ? -op_a : op_a;
    end

    always_comb begin
        hs = acc_reg >>> FRAC_SHIFT;
        if (hs > HIT_HI) begin
            hs_sat = HIT_HI[COORD_WIDTH-1:0];
        end else if (hs < HIT_LO) begin
            hs_sat = HIT_LO[COORD_WIDTH-1:0];
        end else begin
            hs_sat = hs[COORD_WIDTH-1:0];
        end
        sum_uv = un_reg + vn_reg;
        miss = ($unsigned(det_reg) <= AW'(eps_reg)) || un_reg[AW-1] || vn_reg[AW-1]
            || tn_reg[AW-1] || (sum_uv > det_reg);
        sat = tn_reg >= (det_reg <<< SAT_SHIFT);
        rem_shift = {rem_reg[AW-2:0], num_reg[DIST_WIDTH-1]};
    end

    // configuration and best-hit state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0] <= DIR_ONE;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            eps_reg <= '0;
            near_dist_reg <= DIST_MAX;
            near_cell_reg <= '0;
            any_hit_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ORIGIN_X: origin_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                    REG_ORIGIN_Y: origin_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                    REG_ORIGIN_Z: origin_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                    REG_DIR_X: dir_reg[0] <= cfg_data[DIR_WIDTH-1:0];
                    REG_DIR_Y: dir_reg[1] <= cfg_data[DIR_WIDTH-1:0];
                    REG_DIR_Z: dir_reg[2] <= cfg_data[DIR_WIDTH-1:0];
                    REG_DET_EPSILON: eps_reg <= cfg_data[EPS_WIDTH-1:0];
                    default: begin end
                endcase
            end
            if (cmd.op == OP_UPDATE && tri_hit_reg
                && (!any_hit_reg || dist_reg < near_dist_reg)) begin
                near_dist_reg <= dist_reg;
                near_cell_reg <= cell_reg;
                any_hit_reg <= 1'b1;
            end
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
                near_dist_reg <= DIST_MAX;
                near_cell_reg <= '0;
                any_hit_reg <= 1'b0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: begin
                e1_reg[0] <= DW'(s_data.b_x) - DW'(s_data.a_x);
                e1_reg[1] <= DW'(s_data.b_y) - DW'(s_data.a_y);
                e1_reg[2] <= DW'(s_data.b_z) - DW'(s_data.a_z);
                e2_reg[0] <= DW'(s_data.c_x) - DW'(s_data.a_x);
                e2_reg[1] <= DW'(s_data.c_y) - DW'(s_data.a_y);
                e2_reg[2] <= DW'(s_data.c_z) - DW'(s_data.a_z);
                tv_reg[0] <= DW'(origin_reg[0]) - DW'(s_data.a_x);
                tv_reg[1] <= DW'(origin_reg[1]) - DW'(s_data.a_y);
                tv_reg[2] <= DW'(origin_reg[2]) - DW'(s_data.a_z);
                cell_reg <= s_data.cell_index;
                last_reg <= s_data.last_of_query;
            end
            OP_LOAD: begin
                a_reg <= a_load;
                b_reg <= op_b;
                case (op_mode)
                    M_CLEAR: acc_reg <= '0;
                    M_PRESET: acc_reg <= AW'(origin_reg[op_axis]) <<< FRAC_SHIFT;
                    default: begin end
                endcase
            end
            OP_ITER: begin
                if (b_reg[0]) begin
                    acc_reg <= cmd.last_bit ? (acc_reg - a_reg) : (acc_reg + a_reg);
                end
                a_reg <= a_reg <<< 1;
                b_reg <= b_reg >>> 1;
            end
            OP_STORE: begin
                case (cmd.step)
                    S_P0A, S_P0B: p_reg[0] <= acc_reg[PW-1:0];
                    S_P1A, S_P1B: p_reg[1] <= acc_reg[PW-1:0];
                    S_P2A, S_P2B: p_reg[2] <= acc_reg[PW-1:0];
                    S_DET0, S_DET1, S_DET2: det_reg <= acc_reg;
                    S_UN0, S_UN1, S_UN2: un_reg <= acc_reg;
                    S_Q0A, S_Q0B: q_reg[0] <= acc_reg[QW-1:0];
                    S_Q1A, S_Q1B: q_reg[1] <= acc_reg[QW-1:0];
                    S_Q2A, S_Q2B: q_reg[2] <= acc_reg[QW-1:0];
                    S_VN0, S_VN1, S_VN2: vn_reg <= acc_reg;
                    S_TN0, S_TN1, S_TN2: tn_reg <= acc_reg;
                    S_HX: hc_reg[0] <= hs_sat;
                    S_HY: hc_reg[1] <= hs_sat;
                    S_HZ: hc_reg[2] <= hs_sat;
                    default: begin end
                endcase
            end
            OP_NORM: begin
                if (det_reg[AW-1]) begin
                    det_reg <= -det_reg;
                    un_reg <= -un_reg;
                    vn_reg <= -vn_reg;
                    tn_reg <= -tn_reg;
                end
            end
            OP_CHECK: tri_hit_reg <= !miss;
            OP_DIVI: begin
                rem_reg <= tn_reg >>> SAT_SHIFT;
                num_reg <= {tn_reg[SAT_SHIFT-1:0], FRAC_SHIFT'(0)};
                if (sat) begin
                    dist_reg <= DIST_MAX;
                end
            end
            OP_DIV: begin
                num_reg <= num_reg << 1;
                if (rem_shift >= $unsigned(det_reg)) begin
                    rem_reg <= rem_shift - $unsigned(det_reg);
                    dist_reg <= {dist_reg[DIST_WIDTH-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    dist_reg <= {dist_reg[DIST_WIDTH-2:0], 1'b0};
                end
            end
            OP_EMIT: begin
                m_data_reg.hit <= any_hit_reg;
                m_data_reg.best_cell <= near_cell_reg;
                m_data_reg.distance <= any_hit_reg ? near_dist_reg : '0;
                m_data_reg.hit_x <= any_hit_reg ? hc_reg[0] : '0;
                m_data_reg.hit_y <= any_hit_reg ? hc_reg[1] : '0;
                m_data_reg.hit_z <= any_hit_reg ? hc_reg[2] : '0;
            end
            default: begin end
        endcase
    end

    assign status.tri_hit  = tri_hit_reg;
    assign status.sat      = sat;
    assign status.last     = last_reg;
    assign status.any_hit  = any_hit_reg;
    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

FILE: rtl/core/rtch_ctrl.sv
// controller: sequences the multiply steps, division, best-hit update and output
`default_nettype none
module rtch_ctrl import rtch_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rtch_status_t  status,
    output rtch_cmd_t          cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_ITER   = 4'd2;
    localparam logic [3:0] ST_STORE  = 4'd3;
    localparam logic [3:0] ST_NORM   = 4'd4;
    localparam logic [3:0] ST_CHECK  = 4'd5;
    localparam logic [3:0] ST_DIVI   = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_UPDATE = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        s_ready = 1'b0;
        cmd.op = OP_NONE;
        cmd.step = step_reg;
        cmd.last_bit = (cnt_reg == CNT_W'(BW - 1));
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LATCH;
                    step_next = S_P0A;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.op = OP_LOAD;
                cnt_next = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                cmd.op = OP_ITER;
                if (cnt_reg == CNT_W'(BW - 1)) begin
                    state_next = ST_STORE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_STORE: begin
                cmd.op = OP_STORE;
                step_next = step_reg + 1'b1;
                if (step_reg == S_TN2) begin
                    state_next = ST_NORM;
                end else if (step_reg == S_HZ) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_NORM: begin
                cmd.op = OP_NORM;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.op = OP_CHECK;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                cmd.op = OP_DIVI;
                cnt_next = '0;
                if (!status.tri_hit || status.sat) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_UPDATE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                cmd.op = OP_UPDATE;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (status.any_hit) begin
                    step_next = S_HX;
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.op = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ray_triangle_closest_hit.sv
// ray_triangle_closest_hit: one triangle at a time through a shared shift-add multiplier
// each of 24 products is a load, a bit step for each multiplier bit and a store; a triangle runs
// them all plus the divider steps on an unsaturated hit, and the next is accepted only when it is done
// the last triangle of a hit query adds the three hit-point products before the output word,
// which is written once any earlier word has been taken
// reset (aresetn low, synchronous) restores the ray to the origin along +x, epsilon 0,
// and clears the nearest hit and the output valid; the result word register itself is not reset
`default_nettype none
module ray_triangle_closest_hit import rtch_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire tri_word_t                  s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output hit_word_t                       m_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    rtch_cmd_t    cmd;
    rtch_status_t status;

    assign cfg_ready = 1'b1;

    rtch_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rtch_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
